### hw/rtl/msfs_pkg.sv
// Shared types and constants of the multi-row sprite frame sequencer.
// No dependencies; every other file of the block imports this package.
package msfs_pkg;

    // time and frame widths
    localparam int TIME_BITS  = 24;
    localparam int ACC_W      = TIME_BITS + 1;
    localparam int FRAME_W    = 12;
    localparam int CNT_W      = 13;
    localparam int MAX_FRAMES = 4096;

    localparam logic [TIME_BITS-1:0] DEFAULT_FRAME_US = TIME_BITS'(10000);
    localparam logic [ACC_W-1:0]     ACC_MAX          = {ACC_W{1'b1}};
    localparam logic [CNT_W-1:0]     TOTAL_MAX        = CNT_W'(MAX_FRAMES);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TIME_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_TIME   = 3'd0,
        CFG_FRAME_TOTAL  = 3'd1,
        CFG_SHEET_COLS   = 3'd2,
        CFG_LOOP_MODE    = 3'd3,
        CFG_LINGER_FRAME = 3'd4,
        CFG_LINGER_EXTRA = 3'd5
    } t_cfg_idx;

    // shared divider
    localparam int DVD_W     = ACC_W + 1;
    localparam int DVS_W     = TIME_BITS;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

### hw/rtl/msfs_ifs.sv
// Valid/ready channel interfaces: tick input, result output, config writes.
// Depends on msfs_pkg for field widths.
interface msfs_tick_if import msfs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] elapsed_us;

    modport source (output valid, output elapsed_us, input ready);
    modport sink   (input valid, input elapsed_us, output ready);
endinterface

interface msfs_res_if import msfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               active;
    logic [FRAME_W-1:0] frame_index;
    logic [FRAME_W-1:0] sheet_row;
    logic [FRAME_W-1:0] sheet_col;
    logic               done_res;

    modport source (output valid, output active, output frame_index, output sheet_row,
                    output sheet_col, output done_res, input ready);
    modport sink   (input valid, input active, input frame_index, input sheet_row,
                    input sheet_col, input done_res, output ready);
endinterface

interface msfs_cfg_if import msfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/multirow_sprite_frame_sequencer.sv
// Sprite frame sequencer: per tick, accumulate time, advance frames, report row/col.
// A disabled config skips every division; otherwise frames are stepped singly, or in
// loop mode by a bulk wrap of two divisions, and a row/col division follows.
// One tick at a time, ready only when idle.
// The shared divider is a restoring one (one quotient bit per cycle).
// Reset: synchronous active-low; clears state and config, no clearing pass.
module multirow_sprite_frame_sequencer import msfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msfs_cfg_if.sink   i_cfg,
    msfs_tick_if.sink  i_tick,
    msfs_res_if.source o_res
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOOP = 7'b0000010,
        ST_MODF = 7'b0000100,
        ST_DIV1 = 7'b0001000,
        ST_DIV2 = 7'b0010000,
        ST_ROWC = 7'b0100000,
        ST_RCW  = 7'b1000000
    } t_state;

    // configuration registers
    logic [TIME_BITS-1:0] r_frame_time;
    logic [CNT_W-1:0]     r_frame_total;
    logic [CNT_W-1:0]     r_sheet_cols;
    logic                 r_loop_mode;
    logic [CNT_W-1:0]     r_linger_frame;
    logic [TIME_BITS-1:0] r_linger_extra;

    // sequence state
    t_state               r_state, n_state;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [ACC_W-1:0]     r_ll, n_ll;
    logic                 r_ended, n_ended;
    logic                 r_zero, n_zero;

    // output word
    logic                 r_out_valid;
    logic                 r_out_active;
    logic [FRAME_W-1:0]   r_out_frame;
    logic [FRAME_W-1:0]   r_out_row;
    logic [FRAME_W-1:0]   r_out_col;
    logic                 r_out_done;
    logic                 out_load;
    logic                 out_free;

    t_div_req             div_req;
    t_div_rsp             div_rsp;

    logic [TIME_BITS-1:0] ft;
    logic [ACC_W-1:0]     ft_acc;
    logic [CNT_W-1:0]     total;
    logic [CNT_W-1:0]     total_m1;
    logic                 disabled;
    logic                 has_linger;
    logic                 on_linger;
    logic                 guard;
    logic [ACC_W-1:0]     ll_cur;
    logic [ACC_W-1:0]     acc_sub;
    logic [CNT_W-1:0]     frame1;
    logic [CNT_W-1:0]     absf13;
    logic [FRAME_W-1:0]   absf;
    logic [DVD_W-1:0]     acc_sum;
    logic                 advance;
    logic                 tick_acc;

    msfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // effective configuration
    always_comb begin
        ft         = (r_frame_time == '0) ? DEFAULT_FRAME_US : r_frame_time;
        ft_acc     = {1'b0, ft};
        total      = (r_frame_total > TOTAL_MAX) ? TOTAL_MAX : r_frame_total;
        total_m1   = total - CNT_W'(1);
        disabled   = (total <= CNT_W'(1)) || (r_sheet_cols == '0);
        has_linger = !r_linger_frame[CNT_W-1];
        on_linger  = has_linger && (r_frame == r_linger_frame[FRAME_W-1:0])
                     && (r_linger_extra != '0);
        guard      = has_linger && ({1'b0, r_linger_frame[FRAME_W-1:0]} < total)
                     && (r_linger_extra > ft);
        ll_cur     = (r_ll == '0) ? {1'b0, r_linger_extra} : r_ll;
        acc_sub    = r_acc - ft_acc;
        frame1     = {1'b0, r_frame} + CNT_W'(1);
        absf13     = ({1'b0, r_frame} > total_m1) ? total_m1 : {1'b0, r_frame};
        absf       = absf13[FRAME_W-1:0];
        acc_sum    = {1'b0, r_acc} + DVD_W'(i_tick.elapsed_us);
    end

    assign tick_acc = i_tick.valid && i_tick.ready;
    assign out_free = !r_out_valid || o_res.ready;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_frame  = r_frame;
        n_acc    = r_acc;
        n_ll     = r_ll;
        n_ended  = r_ended;
        n_zero   = r_zero;
        advance  = 1'b0;
        out_load = 1'b0;
        div_req  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_acc) begin
                    if (disabled) begin
                        n_zero  = 1'b1;
                        n_state = ST_RCW;
                    end else if (r_ended) begin
                        n_zero  = 1'b0;
                        n_state = ST_ROWC;
                    end else begin
                        n_zero  = 1'b0;
                        n_acc   = acc_sum[DVD_W-1] ? ACC_MAX : acc_sum[ACC_W-1:0];
                        n_state = ST_LOOP;
                    end
                end
            end
            ST_LOOP: begin
                if (r_acc < ft_acc) begin
                    n_state = ST_ROWC;
                end else if (on_linger) begin
                    n_acc = acc_sub;
                    if (ll_cur > ft_acc) begin
                        n_ll    = ll_cur - ft_acc;
                        n_state = ST_ROWC;
                    end else begin
                        n_ll    = '0;
                        advance = 1'b1;
                    end
                end else if (r_loop_mode && !guard) begin
                    // bulk wrap: acc / ft, then (frame + quotient) mod total
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(r_acc);
                    div_req.divisor  = ft;
                    n_state          = ST_DIV1;
                end else begin
                    n_acc   = acc_sub;
                    advance = 1'b1;
                end
                // single frame step
                if (advance) begin
                    if (r_loop_mode) begin
                        if (frame1 < total) begin
                            n_frame = frame1[FRAME_W-1:0];
                        end else if (frame1 == total) begin
                            n_frame = '0;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DVD_W'(frame1);
                            div_req.divisor  = DVS_W'(total);
                            n_state          = ST_MODF;
                        end
                    end else if (frame1 >= total) begin
                        n_frame = total_m1[FRAME_W-1:0];
                        n_ended = 1'b1;
                        n_acc   = '0;
                        n_state = ST_ROWC;
                    end else begin
                        n_frame = frame1[FRAME_W-1:0];
                    end
                end
            end
            ST_MODF: begin
                if (div_rsp.done) begin
                    n_frame = div_rsp.rem[FRAME_W-1:0];
                    n_state = ST_LOOP;
                end
            end
            ST_DIV1: begin
                if (div_rsp.done) begin
                    n_acc            = {1'b0, div_rsp.rem};
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(r_frame) + div_rsp.quot;
                    div_req.divisor  = DVS_W'(total);
                    n_state          = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_rsp.done) begin
                    n_frame = div_rsp.rem[FRAME_W-1:0];
                    n_state = ST_ROWC;
                end
            end
            ST_ROWC: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(absf);
                div_req.divisor  = DVS_W'(r_sheet_cols);
                n_state          = ST_RCW;
            end
            ST_RCW: begin
                if ((r_zero || div_rsp.done) && out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_frame        <= '0;
            r_acc          <= '0;
            r_ll           <= '0;
            r_ended        <= 1'b0;
            r_zero         <= 1'b0;
            r_frame_time   <= '0;
            r_frame_total  <= '0;
            r_sheet_cols   <= '0;
            r_loop_mode    <= 1'b0;
            r_linger_frame <= {CNT_W{1'b1}};
            r_linger_extra <= '0;
        end else begin
            r_state <= n_state;
            r_frame <= n_frame;
            r_acc   <= n_acc;
            r_ll    <= n_ll;
            r_ended <= n_ended;
            r_zero  <= n_zero;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_FRAME_TIME:   r_frame_time   <= i_cfg.data[TIME_BITS-1:0];
                    CFG_FRAME_TOTAL:  r_frame_total  <= i_cfg.data[CNT_W-1:0];
                    CFG_SHEET_COLS:   r_sheet_cols   <= i_cfg.data[CNT_W-1:0];
                    CFG_LOOP_MODE:    r_loop_mode    <= i_cfg.data[0];
                    CFG_LINGER_FRAME: r_linger_frame <= i_cfg.data[CNT_W-1:0];
                    CFG_LINGER_EXTRA: r_linger_extra <= i_cfg.data[TIME_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // output word handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_active <= !r_zero;
            r_out_frame  <= r_zero ? '0 : absf;
            r_out_row    <= r_zero ? '0 : div_rsp.quot[FRAME_W-1:0];
            r_out_col    <= r_zero ? '0 : div_rsp.rem[FRAME_W-1:0];
            r_out_done   <= !r_zero && r_ended;
        end
    end

    assign i_cfg.ready       = 1'b1;
    assign i_tick.ready      = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.active      = r_out_active;
    assign o_res.frame_index = r_out_frame;
    assign o_res.sheet_row   = r_out_row;
    assign o_res.sheet_col   = r_out_col;
    assign o_res.done_res    = r_out_done;

    // an ended sequence keeps an empty accumulator
    a_ended_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> (r_acc == '0))
        else $error("accumulator not empty after sequence end");

    // the shared divider is never restarted mid-operation
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // no division left running when a new tick may come in
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy in idle");

    // bulk wrap leaves less than one frame time
    a_wrap_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV1) && div_rsp.done) |-> (div_rsp.rem < ft))
        else $error("wrap remainder not below frame time");

endmodule

### hw/rtl/msfs_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on msfs_pkg for the request/response structs and widths.
module msfs_div import msfs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0]     r_quot, n_quot;
    logic [DVS_W-1:0]     r_rem, n_rem;
    logic [DVS_W-1:0]     r_dvs, n_dvs;

    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       diff;

    // one trial subtraction per cycle
    always_comb begin
        shifted = {r_rem, r_quot[DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = r_done;
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = DIV_CNT_W'(DVD_W);
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (!diff[DVS_W]) begin
                n_rem  = diff[DVS_W-1:0];
                n_quot = {r_quot[DVD_W-2:0], 1'b1};
            end else begin
                n_rem  = shifted[DVS_W-1:0];
                n_quot = {r_quot[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

### bench/multirow_sprite_frame_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for multirow_sprite_frame_sequencer: directed and random tick streams.
// Depends on msfs_pkg and the channel interfaces in msfs_ifs; predicts every result word.
module multirow_sprite_frame_sequencer_tb;
    import msfs_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_TICKS  = 1800;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_PCT     = 30;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [CNT_W-1:0]     NO_LINGER    = {CNT_W{1'b1}};

    typedef struct packed {
        logic               active;
        logic [FRAME_W-1:0] frame_index;
        logic [FRAME_W-1:0] sheet_row;
        logic [FRAME_W-1:0] sheet_col;
        logic               done_res;
    } t_frame_pos;

    logic i_clk = 1'b0;
    logic i_rst_n;

    msfs_cfg_if  cfg_bus ();
    msfs_tick_if tick_bus ();
    msfs_res_if  res_bus ();

    multirow_sprite_frame_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_tick  (tick_bus),
        .o_res   (res_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // register mirror
    logic [TIME_BITS-1:0] cfg_frame_us;
    logic [CNT_W-1:0]     cfg_total;
    logic [CNT_W-1:0]     cfg_cols;
    logic                 cfg_loop;
    logic [CNT_W-1:0]     cfg_linger_frame;
    logic [TIME_BITS-1:0] cfg_linger_us;

    // sequencer state mirror
    logic [FRAME_W-1:0] seq_frame;
    logic [ACC_W-1:0]   seq_acc;
    logic [ACC_W-1:0]   seq_linger_left;
    logic               seq_ended;

    t_frame_pos frame_pos_q[$];
    int         errors = 0;
    bit         no_stall;
    longint     cycle_count = 0;
    longint     cycle_budget;

    function automatic logic [CNT_W-1:0] clamped_total();
        return (cfg_total > TOTAL_MAX) ? TOTAL_MAX : cfg_total;
    endfunction

    function automatic logic [TIME_BITS-1:0] frame_period();
        return (cfg_frame_us != 0) ? cfg_frame_us : DEFAULT_FRAME_US;
    endfunction

    // Add one tick of time, step frames, and return the reported position.
    function automatic t_frame_pos advance_sequence(input logic [TIME_BITS-1:0] us);
        logic [CNT_W-1:0]     total;
        logic [TIME_BITS-1:0] ft;
        logic [ACC_W:0]       sum;
        logic [ACC_W:0]       laps;
        logic [CNT_W-1:0]     shown;
        logic                 has_linger;
        t_frame_pos           pos;
        pos   = '0;
        total = clamped_total();
        if (total <= 1 || cfg_cols == 0) return pos;
        if (!seq_ended) begin
            sum = {1'b0, seq_acc};
            sum = sum + (ACC_W+1)'(us);
            seq_acc    = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
            ft         = frame_period();
            has_linger = !cfg_linger_frame[CNT_W-1];
            while (seq_acc >= ft) begin
                if (has_linger && {1'b0, seq_frame} == cfg_linger_frame
                    && cfg_linger_us != 0) begin
                    // linger frame: burn one period, hold while linger time remains
                    seq_acc = seq_acc - ft;
                    if (seq_linger_left == 0) seq_linger_left = cfg_linger_us;
                    if (seq_linger_left > ft) begin
                        seq_linger_left = seq_linger_left - ft;
                        break;
                    end
                    seq_linger_left = '0;
                end else if (cfg_loop && !(has_linger && cfg_linger_frame < total
                                           && cfg_linger_us > ft)) begin
                    // loop mode with no linger in reach: take all whole periods at once
                    laps      = seq_acc / ft;
                    seq_acc   = seq_acc % ft;
                    seq_frame = FRAME_W'((seq_frame + laps % total) % total);
                    continue;
                end else begin
                    seq_acc = seq_acc - ft;
                end
                if (cfg_loop) begin
                    seq_frame = FRAME_W'((seq_frame + 1) % total);
                end else if (seq_frame + 1 >= total) begin
                    seq_frame = FRAME_W'(total - 1);
                    seq_ended = 1'b1;
                    seq_acc   = '0;
                    break;
                end else begin
                    seq_frame = seq_frame + 1'b1;
                end
            end
        end
        shown = ({1'b0, seq_frame} > total - CNT_W'(1)) ? total - CNT_W'(1)
                                                         : {1'b0, seq_frame};
        pos.active      = 1'b1;
        pos.frame_index = shown[FRAME_W-1:0];
        pos.sheet_row   = FRAME_W'(shown / cfg_cols);
        pos.sheet_col   = FRAME_W'(shown % cfg_cols);
        pos.done_res    = seq_ended;
        return pos;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // result sink: random backpressure, compare each accepted word
    always @(posedge i_clk) begin
        res_bus.ready <= no_stall || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin : result_check
        t_frame_pos want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (frame_pos_q.size() == 0) begin
                $display("%0t: result word with no tick pending", $time);
                errors++;
            end else begin
                want = frame_pos_q.pop_front();
                check_field("active",      want.active,      res_bus.active);
                check_field("frame_index", want.frame_index, res_bus.frame_index);
                check_field("sheet_row",   want.sheet_row,   res_bus.sheet_row);
                check_field("sheet_col",   want.sheet_col,   res_bus.sheet_col);
                check_field("done_res",    want.done_res,    res_bus.done_res);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_budget) begin
            $display("%0t: timeout, %0d results outstanding", $time, frame_pos_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one tick word, predict its result once it is taken.
    task automatic send_tick(input logic [TIME_BITS-1:0] us);
        int gap;
        gap = 0;
        if (!no_stall) begin
            while ($urandom_range(99) < STALL_PCT) gap++;
        end
        if (gap > 0) begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_bus.valid      <= 1'b1;
        tick_bus.elapsed_us <= us;
        cycle_budget += 1000 + 8 * longint'(clamped_total());
        do @(posedge i_clk); while (!tick_bus.ready);
        frame_pos_q.push_back(advance_sequence(us));
    endtask

    // Drop the tick valid and let every pending result come back.
    task automatic wait_idle();
        tick_bus.valid <= 1'b0;
        cycle_budget += SETTLE_CYCLES + 200;
        while (frame_pos_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        cycle_budget += 100;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_FRAME_TIME:   cfg_frame_us     = value;
            CFG_FRAME_TOTAL:  cfg_total        = value[CNT_W-1:0];
            CFG_SHEET_COLS:   cfg_cols         = value[CNT_W-1:0];
            CFG_LOOP_MODE:    cfg_loop         = value[0];
            CFG_LINGER_FRAME: cfg_linger_frame = value[CNT_W-1:0];
            CFG_LINGER_EXTRA: cfg_linger_us    = value;
            default: ;
        endcase
    endtask

    task automatic close_setup();
        cfg_bus.valid <= 1'b0;
    endtask

    // Full register load, done only with the block idle.
    task automatic setup(input logic [TIME_BITS-1:0] ft, input logic [CNT_W-1:0] total,
                         input logic [CNT_W-1:0] cols, input logic loop,
                         input logic [CNT_W-1:0] linger, input logic [TIME_BITS-1:0] extra);
        wait_idle();
        set_reg(CFG_FRAME_TIME, ft);
        set_reg(CFG_FRAME_TOTAL, CFG_DATA_W'(total));
        set_reg(CFG_SHEET_COLS, CFG_DATA_W'(cols));
        set_reg(CFG_LOOP_MODE, CFG_DATA_W'(loop));
        set_reg(CFG_LINGER_FRAME, CFG_DATA_W'(linger));
        set_reg(CFG_LINGER_EXTRA, extra);
        close_setup();
    endtask

    function automatic logic [TIME_BITS-1:0] pick_elapsed();
        logic [TIME_BITS-1:0] ft;
        ft = frame_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return TIME_BITS'($urandom());
            4, 5, 6: return TIME_BITS'($urandom_range(0, ft));
            default: return TIME_BITS'(ft * $urandom_range(1, 5) + $urandom_range(0, 3));
        endcase
    endfunction

    // Reset config, spare index writes, a one-frame total and zero columns: all-zero results, state frozen.
    task automatic test_disabled();
        send_tick('0);
        send_tick('1);
        wait_idle();
        set_reg(CFG_SPARE_LO, '1);
        set_reg(CFG_SPARE_HI, '1);
        close_setup();
        setup(0, 1, 3, 1'b0, NO_LINGER, 0);
        send_tick('1);
        setup(0, 5, 0, 1'b0, NO_LINGER, 0);
        send_tick(24'd20000);
    endtask

    // Default period in loop mode, including a multi-frame wrap in one tick.
    task automatic test_loop_wrap();
        setup(0, 7, 3, 1'b1, NO_LINGER, 0);
        send_tick(24'd9999);
        send_tick(24'd1);
        send_tick(24'd95000);
    endtask

    // Linger frame longer than a period forces single frame steps.
    task automatic test_linger_hold();
        int n;
        setup(100, 6, 4, 1'b1, 2, 250);
        for (n = 0; n < 5; n++) send_tick(24'd100);
        send_tick(24'd1000);
    endtask

    // Park on the current frame with a huge linger until the accumulator pins.
    task automatic test_acc_saturation();
        int n;
        wait_idle();
        setup(1, 6, 4, 1'b1, {1'b0, seq_frame}, '1);
        for (n = 0; n < 3; n++) send_tick('1);
        // most negative linger index: no linger, bulk step of the pinned accumulator
        setup(1, 6, 4, 1'b1, {1'b1, {(CNT_W-1){1'b0}}}, '1);
        send_tick('0);
    endtask

    // Oversized total and column count, then a frame past a reduced total.
    task automatic test_oversized_total();
        setup(1, '1, '1, 1'b1, NO_LINGER, 0);
        send_tick(24'd3000);
        setup(1, 10, 4096, 1'b1, NO_LINGER, 0);
        send_tick('0);
        send_tick(24'd1);
    endtask

    // Random setups and ticks; non-loop phases are kept short of the sequence end.
    task automatic test_random_ticks();
        int                   sent;
        int                   phase_len;
        int                   n;
        bit                   enabled;
        logic [TIME_BITS-1:0] ft;
        logic [TIME_BITS-1:0] us;
        logic [TIME_BITS-1:0] extra;
        logic [TIME_BITS-1:0] ft_eff;
        logic [CNT_W-1:0]     total;
        logic [CNT_W-1:0]     cols;
        logic [CNT_W-1:0]     linger;
        logic [CNT_W-1:0]     reach;
        longint               allowed;
        longint               cap;
        sent = 0;
        while (sent < RANDOM_TICKS) begin
            no_stall = (sent > RANDOM_TICKS / 4) && (sent < RANDOM_TICKS * 2 / 5);
            case ($urandom_range(9))
                0:       ft = '0;
                1:       ft = '1;
                2, 3:    ft = TIME_BITS'($urandom_range(1, 64));
                4, 5, 6: ft = TIME_BITS'($urandom_range(100, 20000));
                default: ft = TIME_BITS'($urandom());
            endcase
            case ($urandom_range(19))
                0:       total = CNT_W'($urandom_range(0, 1));
                1:       total = TOTAL_MAX;
                2:       total = CNT_W'($urandom_range(MAX_FRAMES + 1, 8191));
                3:       total = CNT_W'($urandom_range(65, MAX_FRAMES - 1));
                default: total = CNT_W'($urandom_range(2, 40));
            endcase
            case ($urandom_range(15))
                0:       cols = '0;
                1:       cols = CNT_W'($urandom_range(4096, 8191));
                2:       cols = CNT_W'(1);
                default: cols = CNT_W'($urandom_range(2, 12));
            endcase
            reach = (total > CNT_W'(4094)) ? CNT_W'(4095) : total + CNT_W'(1);
            case ($urandom_range(3))
                0:       linger = NO_LINGER;
                1:       linger = {1'b1, FRAME_W'($urandom())};
                default: linger = CNT_W'($urandom_range(0, reach));
            endcase
            ft_eff = (ft != 0) ? ft : DEFAULT_FRAME_US;
            case ($urandom_range(5))
                0:       extra = '0;
                1:       extra = '1;
                2:       extra = TIME_BITS'($urandom());
                default: extra = TIME_BITS'($urandom_range(1, ft_eff * 3));
            endcase
            setup(ft, total, cols, $urandom_range(4) < 3, linger, extra);
            if ($urandom_range(7) == 0) begin
                set_reg(CFG_SPARE_HI, TIME_BITS'($urandom()));
                close_setup();
            end
            enabled = (clamped_total() > 1) && (cfg_cols != 0);
            if (!enabled)                    phase_len = 3;
            else if (clamped_total() > 64)   phase_len = $urandom_range(1, 6);
            else                             phase_len = $urandom_range(10, 60);
            for (n = 0; n < phase_len; n++) begin
                us = pick_elapsed();
                if (enabled && !cfg_loop) begin
                    // frames advanced <= total time / period; stay below the end
                    allowed = (longint'(seq_frame) <= longint'(clamped_total()) - 1)
                            ? longint'(clamped_total()) - 1 - longint'(seq_frame) : 0;
                    cap = (allowed + 1) * longint'(frame_period()) - longint'(seq_acc) - 1;
                    if (cap < 0) break;
                    if (longint'(us) > cap)
                        us = TIME_BITS'($urandom_range(0, (cap > 24'hFFFFFF) ? 24'hFFFFFF : cap));
                end
                send_tick(us);
                if (enabled) sent++;
            end
        end
        no_stall = 0;
    endtask

    // Non-loop run onto the last frame, ticks after the end, then a smaller total.
    task automatic test_stop_at_end();
        int n;
        setup('1, 4, 3, 1'b0, 4095, '1);
        for (n = 0; n < 4; n++) send_tick('1);
        send_tick(24'd5);
        setup(0, 2, 1, 1'b0, NO_LINGER, 0);
        send_tick('0);
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        tick_bus.valid      <= 1'b0;
        tick_bus.elapsed_us <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= CFG_FRAME_TIME;
        cfg_bus.data        <= '0;
        no_stall         = 0;
        cycle_budget     = 20000;
        cfg_frame_us     = '0;
        cfg_total        = '0;
        cfg_cols         = '0;
        cfg_loop         = 1'b0;
        cfg_linger_frame = NO_LINGER;
        cfg_linger_us    = '0;
        seq_frame        = '0;
        seq_acc          = '0;
        seq_linger_left  = '0;
        seq_ended        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled();
        test_loop_wrap();
        test_linger_hold();
        test_acc_saturation();
        test_oversized_total();
        test_random_ticks();
        test_stop_at_end();
        wait_idle();

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/msfs_pkg.sv
hw/rtl/msfs_ifs.sv
hw/rtl/msfs_div.sv
hw/rtl/multirow_sprite_frame_sequencer.sv
bench/multirow_sprite_frame_sequencer_tb.sv
